FILE: sv/gpr_pkg.sv
// Package for the GPIO port register block.
// Holds register index codes, field widths and the request and response structs.
// No dependencies.
`timescale 1ns / 1ps

package gpr_pkg;

    // Field widths of the request and response.
    localparam int LOW_W      = 32;
    localparam int HIGH_W     = 22;
    localparam int IDX_W      = 6;
    localparam int PIN_MAX    = 64;

    // Function select layout: 10 pins of 3 bits in each of 6 registers.
    localparam int FSEL_REGS     = 6;
    localparam int FSEL_W        = 30;
    localparam int FSEL_FIELD_W  = 3;
    localparam int PINS_PER_FSEL = 10;

    // Pull field layout: 16 pins of 2 bits in each of 4 words.
    localparam int PULL_WORDS    = 4;
    localparam int PULL_W        = 32;
    localparam int PULL_FIELD_W  = 2;
    localparam int PINS_PER_PULL = 16;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic CFG_IDX_SCHEME = 1'b0;

    // Access codes.
    localparam logic OP_WRITE = 1'b1;
    localparam logic [FSEL_FIELD_W-1:0] FSEL_OUTPUT = 3'b001;

    // Register word indices.
    localparam logic [IDX_W-1:0] IDX_FSEL_LAST = 6'd5;
    localparam logic [IDX_W-1:0] IDX_SET0      = 6'd7;
    localparam logic [IDX_W-1:0] IDX_SET1      = 6'd8;
    localparam logic [IDX_W-1:0] IDX_CLR0      = 6'd10;
    localparam logic [IDX_W-1:0] IDX_CLR1      = 6'd11;
    localparam logic [IDX_W-1:0] IDX_LEV0      = 6'd13;
    localparam logic [IDX_W-1:0] IDX_LEV1      = 6'd14;
    localparam logic [IDX_W-1:0] IDX_PUD       = 6'd37;
    localparam logic [IDX_W-1:0] IDX_PUDCLK0   = 6'd38;
    localparam logic [IDX_W-1:0] IDX_PUDCLK1   = 6'd39;
    localparam logic [IDX_W-1:0] IDX_PULL0     = 6'd57;
    localparam logic [IDX_W-1:0] IDX_PULL3     = 6'd60;

    // Identity word read at the last pull index in the legacy scheme.
    localparam logic [LOW_W-1:0] IDENT_WORD = 32'h6770696f;

    // One bus access as it enters the decode stage.
    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  reg_index;
        logic [LOW_W-1:0]  write_data;
        logic [LOW_W-1:0]  pins_in_low;
        logic [HIGH_W-1:0] pins_in_high;
    } t_req;

    // The result of one access.
    typedef struct packed {
        logic [LOW_W-1:0]  read_data;
        logic              unmapped;
        logic [LOW_W-1:0]  drive_low;
        logic [HIGH_W-1:0] drive_high;
        logic [LOW_W-1:0]  enable_low;
        logic [HIGH_W-1:0] enable_high;
    } t_rsp;

endpackage

FILE: sv/gpr_if.sv
// Valid/ready channel interfaces for the GPIO port register block.
// Depends on gpr_pkg for field widths.
`timescale 1ns / 1ps

// Request channel: one bus access per transfer.
interface gpr_req_if import gpr_pkg::*; ;
    logic              valid;
    logic              ready;
    logic              op;
    logic [IDX_W-1:0]  reg_index;
    logic [LOW_W-1:0]  write_data;
    logic [LOW_W-1:0]  pins_in_low;
    logic [HIGH_W-1:0] pins_in_high;

    modport source (
        output valid, op, reg_index, write_data, pins_in_low, pins_in_high,
        input  ready
    );
    modport sink (
        input  valid, op, reg_index, write_data, pins_in_low, pins_in_high,
        output ready
    );
endinterface

// Response channel: read data, unmapped flag and pin vectors.
interface gpr_rsp_if import gpr_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [LOW_W-1:0]  read_data;
    logic              unmapped;
    logic [LOW_W-1:0]  drive_low;
    logic [HIGH_W-1:0] drive_high;
    logic [LOW_W-1:0]  enable_low;
    logic [HIGH_W-1:0] enable_high;

    modport source (
        output valid, read_data, unmapped, drive_low, drive_high, enable_low,
               enable_high,
        input  ready
    );
    modport sink (
        input  valid, read_data, unmapped, drive_low, drive_high, enable_low,
               enable_high,
        output ready
    );
endinterface

FILE: sv/gpr_regs.sv
// Register file and access decode of the GPIO port register block.
// Depends on gpr_pkg for index codes, widths and the request/response structs.
`timescale 1ns / 1ps

module gpr_regs import gpr_pkg::*; #(
    parameter int PIN_COUNT = 54
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_req i_req,
    input  logic i_new_pull,
    output t_rsp o_rsp
);

    // Writable bits of one function select register.
    function automatic logic [FSEL_W-1:0] fsel_mask(input int reg_n);
        logic [FSEL_W-1:0] m;
        m = '0;
        for (int k = 0; k < PINS_PER_FSEL; k++) begin
            if (reg_n * PINS_PER_FSEL + k < PIN_COUNT) begin
                m[FSEL_FIELD_W*k +: FSEL_FIELD_W] = '1;
            end
        end
        return m;
    endfunction

    // Writable bits of one pull field word.
    function automatic logic [PULL_W-1:0] pull_mask(input int word_n);
        logic [PULL_W-1:0] m;
        m = '0;
        for (int k = 0; k < PINS_PER_PULL; k++) begin
            if (word_n * PINS_PER_PULL + k < PIN_COUNT) begin
                m[PULL_FIELD_W*k +: PULL_FIELD_W] = '1;
            end
        end
        return m;
    endfunction

    logic [FSEL_W-1:0]    r_fsel [FSEL_REGS];
    logic [FSEL_W-1:0]    n_fsel [FSEL_REGS];
    logic [PIN_COUNT-1:0] r_latch;
    logic [PIN_COUNT-1:0] n_latch;
    logic [PULL_W-1:0]    r_pull [PULL_WORDS];
    logic [PULL_W-1:0]    n_pull [PULL_WORDS];
    logic [1:0]           r_code;
    logic [1:0]           n_code;

    logic [FSEL_W-1:0]    w_fsel_mask [FSEL_REGS];
    logic [PULL_W-1:0]    w_pull_mask [PULL_WORDS];
    wire  [PIN_COUNT-1:0] w_en_cur;
    wire  [PIN_COUNT-1:0] w_en_nxt;
    wire  [PINS_PER_PULL-1:0] w_legacy_sel [PULL_WORDS];

    logic                 w_wr;
    logic [PIN_MAX-1:0]   w_wd_pins;
    logic [PIN_COUNT-1:0] w_wd_pin;
    logic [PIN_MAX-1:0]   w_ext64;
    logic [PIN_MAX-1:0]   w_lev64;
    logic [PIN_MAX-1:0]   w_latch64;
    logic [PIN_MAX-1:0]   w_en64;
    logic [IDX_W-1:0]     w_pull_off;
    logic [1:0]           w_pull_sel;
    logic                 w_legacy_wr;
    logic [LOW_W-1:0]     w_rd;
    logic                 w_unm;

    // Per-register write masks, fixed at elaboration.
    genvar g, k;
    generate
        for (g = 0; g < FSEL_REGS; g++) begin : g_fmask
            localparam logic [FSEL_W-1:0] MASK = fsel_mask(g);
            assign w_fsel_mask[g] = MASK;
        end
        for (g = 0; g < PULL_WORDS; g++) begin : g_pmask
            localparam logic [PULL_W-1:0] MASK = pull_mask(g);
            assign w_pull_mask[g] = MASK;
        end
    endgenerate

    // Output enables from the current and the next function selects.
    generate
        for (g = 0; g < PIN_COUNT; g++) begin : g_en
            if (g < FSEL_REGS * PINS_PER_FSEL) begin : g_sel
                localparam int R = g / PINS_PER_FSEL;
                localparam int S = FSEL_FIELD_W * (g % PINS_PER_FSEL);
                assign w_en_cur[g] = (r_fsel[R][S +: FSEL_FIELD_W] == FSEL_OUTPUT);
                assign w_en_nxt[g] = (n_fsel[R][S +: FSEL_FIELD_W] == FSEL_OUTPUT);
            end else begin : g_none
                assign w_en_cur[g] = 1'b0;
                assign w_en_nxt[g] = 1'b0;
            end
        end
    endgenerate

    // Pins picked by a legacy pull clock write.
    generate
        for (g = 0; g < PULL_WORDS; g++) begin : g_lw
            for (k = 0; k < PINS_PER_PULL; k++) begin : g_lp
                if (g * PINS_PER_PULL + k < PIN_COUNT) begin : g_on
                    assign w_legacy_sel[g][k] = w_wd_pins[g * PINS_PER_PULL + k];
                end else begin : g_off
                    assign w_legacy_sel[g][k] = 1'b0;
                end
            end
        end
    endgenerate

    // Data word placed on the pin vector: upper registers cover pins 32 and up.
    always_comb begin
        w_wr = (i_req.op == OP_WRITE);
        if (i_req.reg_index == IDX_SET1 || i_req.reg_index == IDX_CLR1 ||
            i_req.reg_index == IDX_PUDCLK1) begin
            w_wd_pins = {i_req.write_data, {LOW_W{1'b0}}};
        end else begin
            w_wd_pins = {{LOW_W{1'b0}}, i_req.write_data};
        end
        w_wd_pin = w_wd_pins[PIN_COUNT-1:0];
        w_ext64 = {{(PIN_MAX-LOW_W-HIGH_W){1'b0}}, i_req.pins_in_high, i_req.pins_in_low};
        w_lev64 = '0;
        w_lev64[PIN_COUNT-1:0] = (r_latch & w_en_cur) |
                                 (w_ext64[PIN_COUNT-1:0] & ~w_en_cur);
        w_pull_off = i_req.reg_index - IDX_PULL0;
        w_pull_sel = w_pull_off[1:0];
    end

    // Access decode and next state.
    always_comb begin
        n_fsel      = r_fsel;
        n_latch     = r_latch;
        n_pull      = r_pull;
        n_code      = r_code;
        w_rd        = '0;
        w_unm       = 1'b0;
        w_legacy_wr = 1'b0;

        if (i_req.reg_index <= IDX_FSEL_LAST) begin
            if (w_wr) begin
                n_fsel[i_req.reg_index[2:0]] =
                    i_req.write_data[FSEL_W-1:0] & w_fsel_mask[i_req.reg_index[2:0]];
            end else begin
                w_rd = {{(LOW_W-FSEL_W){1'b0}}, r_fsel[i_req.reg_index[2:0]]};
            end
        end else if (i_req.reg_index == IDX_SET0 || i_req.reg_index == IDX_SET1) begin
            if (w_wr) begin
                n_latch = r_latch | w_wd_pin;
            end
        end else if (i_req.reg_index == IDX_CLR0 || i_req.reg_index == IDX_CLR1) begin
            if (w_wr) begin
                n_latch = r_latch & ~w_wd_pin;
            end
        end else if (i_req.reg_index == IDX_LEV0 || i_req.reg_index == IDX_LEV1) begin
            if (!w_wr) begin
                w_rd = (i_req.reg_index == IDX_LEV1) ? w_lev64[PIN_MAX-1:LOW_W]
                                                     : w_lev64[LOW_W-1:0];
            end
        end else if (!i_new_pull && i_req.reg_index == IDX_PUD) begin
            if (w_wr) begin
                n_code = i_req.write_data[1:0];
            end else begin
                w_rd = {{(LOW_W-2){1'b0}}, r_code};
            end
        end else if (!i_new_pull && (i_req.reg_index == IDX_PUDCLK0 ||
                                     i_req.reg_index == IDX_PUDCLK1)) begin
            w_legacy_wr = w_wr;
        end else if (i_new_pull && i_req.reg_index >= IDX_PULL0 &&
                     i_req.reg_index <= IDX_PULL3) begin
            if (w_wr) begin
                n_pull[w_pull_sel] = i_req.write_data & w_pull_mask[w_pull_sel];
            end else begin
                w_rd = r_pull[w_pull_sel];
            end
        end else if (!i_new_pull && i_req.reg_index == IDX_PULL3) begin
            if (!w_wr) begin
                w_rd = IDENT_WORD;
            end
        end else begin
            w_unm = 1'b1;
        end

        // Legacy clock write copies the held code into every selected pin.
        for (int w = 0; w < PULL_WORDS; w++) begin
            for (int p = 0; p < PINS_PER_PULL; p++) begin
                if (w_legacy_wr && w_legacy_sel[w][p]) begin
                    n_pull[w][PULL_FIELD_W*p +: PULL_FIELD_W] = r_code;
                end
            end
        end
    end

    // Result fields, showing the state after this access.
    always_comb begin
        w_latch64 = '0;
        w_latch64[PIN_COUNT-1:0] = n_latch;
        w_en64 = '0;
        w_en64[PIN_COUNT-1:0] = w_en_nxt;
        o_rsp.read_data   = w_wr ? '0 : w_rd;
        o_rsp.unmapped    = w_unm;
        o_rsp.drive_low   = w_latch64[LOW_W-1:0];
        o_rsp.drive_high  = w_latch64[LOW_W +: HIGH_W];
        o_rsp.enable_low  = w_en64[LOW_W-1:0];
        o_rsp.enable_high = w_en64[LOW_W +: HIGH_W];
    end

    // State registers, updated once per decoded access.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < FSEL_REGS; r++) begin
                r_fsel[r] <= '0;
            end
            for (int w = 0; w < PULL_WORDS; w++) begin
                r_pull[w] <= '0;
            end
            r_latch <= '0;
            r_code  <= '0;
        end else if (i_en) begin
            r_fsel  <= n_fsel;
            r_pull  <= n_pull;
            r_latch <= n_latch;
            r_code  <= n_code;
        end
    end

endmodule

FILE: sv/gpio_port_registers_core.sv
// Top level of the GPIO port register block: channels, configuration port, pipeline.
// Depends on gpr_pkg, gpr_if (gpr_req_if, gpr_rsp_if) and gpr_regs.
`timescale 1ns / 1ps

// Each request is one register access. It is taken into an input register, decoded
// and applied to the register file once the output register is free, and its
// response lands in that output register.
// One request is accepted every cycle while responses are taken; the single decode
// stage between the input and output registers sets that rate. The output register
// lets a new request in while an earlier response still waits. The pull scheme is
// chosen by register 0 of the configuration port (byte address 0) and should be
// changed only while no access is in flight. No clearing pass follows reset.
module gpio_port_registers_core import gpr_pkg::*; #(
    parameter int PIN_COUNT = 54
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gpr_req_if.sink               i_req,
    gpr_rsp_if.source             o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic r_new_pull;
    logic r_in_valid;
    logic n_in_valid;
    t_req r_in;
    logic r_out_valid;
    logic n_out_valid;
    t_rsp r_out;

    logic w_req_acc;
    logic w_out_free;
    logic w_advance;
    logic w_cfg_wr;
    t_rsp w_rsp;

    // Configuration port: one register, zero wait states.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_SCHEME);
    assign prdata   = (paddr[2] == CFG_IDX_SCHEME) ? {{(CFG_DATA_W-1){1'b0}}, r_new_pull}
                                                   : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_new_pull <= 1'b0;
        end else if (w_cfg_wr) begin
            r_new_pull <= pwdata[0];
        end
    end

    // Pipeline flow control.
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_advance   = r_in_valid && w_out_free;
    assign i_req.ready = !r_in_valid || w_advance;
    assign w_req_acc   = i_req.valid && i_req.ready;
    assign n_in_valid  = w_req_acc || (r_in_valid && !w_advance);
    assign n_out_valid = w_advance || (r_out_valid && !o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Input and output payload registers.
    always_ff @(posedge i_clk) begin
        if (w_req_acc) begin
            r_in.op           <= i_req.op;
            r_in.reg_index    <= i_req.reg_index;
            r_in.write_data   <= i_req.write_data;
            r_in.pins_in_low  <= i_req.pins_in_low;
            r_in.pins_in_high <= i_req.pins_in_high;
        end
        if (w_advance) begin
            r_out <= w_rsp;
        end
    end

    // Register file and decode.
    gpr_regs #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_advance),
        .i_req      (r_in),
        .i_new_pull (r_new_pull),
        .o_rsp      (w_rsp)
    );

    // Response channel.
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_data   = r_out.read_data;
    assign o_rsp.unmapped    = r_out.unmapped;
    assign o_rsp.drive_low   = r_out.drive_low;
    assign o_rsp.drive_high  = r_out.drive_high;
    assign o_rsp.enable_low  = r_out.enable_low;
    assign o_rsp.enable_high = r_out.enable_high;

endmodule

FILE: sv/gpr_core_checker.sv
// Port-level checks for gpio_port_registers_core, bound to the top level.
// Depends on gpr_pkg for field widths.
`timescale 1ns / 1ps

module gpr_core_checker import gpr_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input logic [LOW_W-1:0] i_rsp_read_data,
    input logic             i_rsp_unmapped
);

    // A stalled response keeps its data.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_read_data) &&
                                        $stable(i_rsp_unmapped))
        else $error("response changed while stalled");

    // An unmapped access never returns data.
    a_unmapped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_unmapped |-> i_rsp_read_data == '0)
        else $error("unmapped access returned nonzero data");

    // Nothing is presented right after reset is released.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_rsp_valid)
        else $error("response valid right after reset");

    // With the response side taking data, an accepted request is answered from the output register.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) ##1 i_rsp_ready |=> i_rsp_valid)
        else $error("response missing two cycles after request");

endmodule

bind gpio_port_registers_core gpr_core_checker u_gpr_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_read_data (o_rsp.read_data),
    .i_rsp_unmapped  (o_rsp.unmapped)
);

FILE: sim/gpio_access_checker.sv
// Checker for the GPIO port register block: watches the request, response and config ports.
// Predicts each response from its own register model and compares it field by field.
// Depends on gpr_pkg and gpr_if (gpr_req_if, gpr_rsp_if).
`timescale 1ns / 1ps

module gpio_access_checker import gpr_pkg::*; #(
    parameter int PIN_COUNT = 54
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gpr_req_if                    req_ch,
    gpr_rsp_if                    rsp_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    o_pending,
    output int                    o_fail_count
);

    localparam logic [63:0] PIN_MASK = (64'd1 << PIN_COUNT) - 64'd1;
    localparam logic [CFG_ADDR_W-1:0] SCHEME_ADDR = CFG_ADDR_W'(CFG_IDX_SCHEME) << 2;

    // Register model of the block.
    logic [FSEL_W-1:0] fsel_q [FSEL_REGS];
    logic [63:0]       latch_q;
    logic [PULL_W-1:0] pull_q [PULL_WORDS];
    logic [1:0]        pud_code_q;
    logic              new_scheme_q;

    // Responses predicted for accepted requests, oldest first.
    t_rsp awaited_rsps [$];
    t_rsp head_rsp;
    t_rsp predicted_rsp;
    t_req seen_req;
    int   fail_tally;

    assign o_fail_count = fail_tally;

    // Bits of a function select register that belong to existing pins.
    function automatic logic [FSEL_W-1:0] fsel_keep(input int r);
        logic [FSEL_W-1:0] m;
        m = '0;
        for (int k = 0; k < PINS_PER_FSEL; k++) begin
            if (r * PINS_PER_FSEL + k < PIN_COUNT) begin
                m[k*FSEL_FIELD_W +: FSEL_FIELD_W] = '1;
            end
        end
        return m;
    endfunction

    // Bits of a pull word that belong to existing pins.
    function automatic logic [PULL_W-1:0] pull_keep(input int w);
        logic [PULL_W-1:0] m;
        m = '0;
        for (int k = 0; k < PINS_PER_PULL; k++) begin
            if (w * PINS_PER_PULL + k < PIN_COUNT) begin
                m[k*PULL_FIELD_W +: PULL_FIELD_W] = '1;
            end
        end
        return m;
    endfunction

    // A pin drives when its select field holds the output code.
    function automatic logic [63:0] drive_enables();
        logic [63:0] en;
        en = '0;
        for (int p = 0; p < FSEL_REGS * PINS_PER_FSEL && p < PIN_COUNT; p++) begin
            if (fsel_q[p / PINS_PER_FSEL][FSEL_FIELD_W * (p % PINS_PER_FSEL) +: FSEL_FIELD_W]
                    == FSEL_OUTPUT) begin
                en[p] = 1'b1;
            end
        end
        return en;
    endfunction

    // Apply one access to the model and work out its response.
    task automatic predict_access(input t_req acc, output t_rsp rsp);
        logic        wr;
        logic [31:0] rd;
        logic        unm;
        logic [63:0] ext;
        logic [63:0] en;
        logic [63:0] lev;
        logic [63:0] pins;
        logic [IDX_W-1:0] idx;
        int          w;
        wr  = (acc.op == OP_WRITE);
        idx = acc.reg_index;
        rd  = '0;
        unm = 1'b0;
        ext = 64'({acc.pins_in_high, acc.pins_in_low}) & PIN_MASK;
        if (idx <= IDX_FSEL_LAST) begin
            if (wr) begin
                fsel_q[idx[2:0]] = acc.write_data[FSEL_W-1:0] & fsel_keep(int'(idx));
            end else begin
                rd = 32'(fsel_q[idx[2:0]]);
            end
        end else if (idx == IDX_SET0 || idx == IDX_SET1) begin
            if (wr) begin
                latch_q |= (64'(acc.write_data) << (idx == IDX_SET1 ? 32 : 0)) & PIN_MASK;
            end
        end else if (idx == IDX_CLR0 || idx == IDX_CLR1) begin
            if (wr) begin
                latch_q &= ~((64'(acc.write_data) << (idx == IDX_CLR1 ? 32 : 0)) & PIN_MASK);
            end
        end else if (idx == IDX_LEV0 || idx == IDX_LEV1) begin
            if (!wr) begin
                en  = drive_enables();
                lev = ((latch_q & en) | (ext & ~en)) & PIN_MASK;
                rd  = (idx == IDX_LEV1) ? lev[63:32] : lev[31:0];
            end
        end else if (!new_scheme_q && idx == IDX_PUD) begin
            if (wr) begin
                pud_code_q = acc.write_data[1:0];
            end else begin
                rd = 32'(pud_code_q);
            end
        end else if (!new_scheme_q && (idx == IDX_PUDCLK0 || idx == IDX_PUDCLK1)) begin
            // Legacy clock write: copy the held code into every selected pin.
            if (wr) begin
                pins = (64'(acc.write_data) << (idx == IDX_PUDCLK1 ? 32 : 0)) & PIN_MASK;
                for (int p = 0; p < 64; p++) begin
                    if (pins[p]) begin
                        pull_q[p / PINS_PER_PULL][PULL_FIELD_W * (p % PINS_PER_PULL) +:
                            PULL_FIELD_W] = pud_code_q;
                    end
                end
            end
        end else if (new_scheme_q && idx >= IDX_PULL0 && idx <= IDX_PULL3) begin
            w = int'(idx - IDX_PULL0);
            if (wr) begin
                pull_q[w] = acc.write_data & pull_keep(w);
            end else begin
                rd = pull_q[w];
            end
        end else if (!new_scheme_q && idx == IDX_PULL3) begin
            if (!wr) begin
                rd = IDENT_WORD;
            end
        end else begin
            unm = 1'b1;
        end
        en = drive_enables();
        rsp.read_data   = wr ? '0 : rd;
        rsp.unmapped    = unm;
        rsp.drive_low   = latch_q[31:0];
        rsp.drive_high  = latch_q[32 +: HIGH_W];
        rsp.enable_low  = en[31:0];
        rsp.enable_high = en[32 +: HIGH_W];
    endtask

    // One line per mismatch, and every mismatch is counted.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch in %s: got 0x%08h, want 0x%08h", $time, what, got,
                 want);
        fail_tally++;
    endtask

    // Compare responses, then predict for the request taken at this edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FSEL_REGS; i++) fsel_q[i] = '0;
            for (int i = 0; i < PULL_WORDS; i++) pull_q[i] = '0;
            latch_q      = '0;
            pud_code_q   = '0;
            new_scheme_q = 1'b0;
            fail_tally   = 0;
            awaited_rsps.delete();
            o_pending <= 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (awaited_rsps.size() == 0) begin
                    report_mismatch("response with none awaited", rsp_ch.read_data, '0);
                end else begin
                    head_rsp = awaited_rsps.pop_front();
                    if (rsp_ch.read_data !== head_rsp.read_data)
                        report_mismatch("read_data", rsp_ch.read_data, head_rsp.read_data);
                    if (rsp_ch.unmapped !== head_rsp.unmapped)
                        report_mismatch("unmapped", 32'(rsp_ch.unmapped),
                                        32'(head_rsp.unmapped));
                    if (rsp_ch.drive_low !== head_rsp.drive_low)
                        report_mismatch("drive_low", rsp_ch.drive_low, head_rsp.drive_low);
                    if (rsp_ch.drive_high !== head_rsp.drive_high)
                        report_mismatch("drive_high", 32'(rsp_ch.drive_high),
                                        32'(head_rsp.drive_high));
                    if (rsp_ch.enable_low !== head_rsp.enable_low)
                        report_mismatch("enable_low", rsp_ch.enable_low,
                                        head_rsp.enable_low);
                    if (rsp_ch.enable_high !== head_rsp.enable_high)
                        report_mismatch("enable_high", 32'(rsp_ch.enable_high),
                                        32'(head_rsp.enable_high));
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                seen_req.op           = req_ch.op;
                seen_req.reg_index    = req_ch.reg_index;
                seen_req.write_data   = req_ch.write_data;
                seen_req.pins_in_low  = req_ch.pins_in_low;
                seen_req.pins_in_high = req_ch.pins_in_high;
                predict_access(seen_req, predicted_rsp);
                awaited_rsps.push_back(predicted_rsp);
            end
            if (psel && penable && pwrite && pready && paddr == SCHEME_ADDR) begin
                new_scheme_q = pwdata[0];
            end
            o_pending <= awaited_rsps.size();
        end
    end

endmodule

FILE: sim/tb.sv
// Testbench top for the GPIO port register block: clock, reset, request and config stimulus.
// Depends on gpr_pkg, gpr_if, gpio_port_registers_core and gpio_access_checker.
`timescale 1ns / 1ps

module tb;
    import gpr_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [CFG_ADDR_W-1:0] SCHEME_ADDR = CFG_ADDR_W'(CFG_IDX_SCHEME) << 2;
    localparam logic [IDX_W-1:0] IDX_GAP = IDX_FSEL_LAST + 6'd1;
    localparam logic [IDX_W-1:0] IDX_TOP = '1;
    localparam logic [LOW_W-1:0] ALL_OUTPUT = LOW_W'({PINS_PER_FSEL{FSEL_OUTPUT}});

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int pending;
    int fail_count;
    int src_idle_pct;
    int snk_idle_pct;
    int stall_cycles;

    gpr_req_if req_ch ();
    gpr_rsp_if rsp_ch ();

    gpio_port_registers_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    gpio_access_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req_ch       (req_ch),
        .rsp_ch       (rsp_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Free-running clock, 20 ns period.
    always #10 i_clk = ~i_clk;

    // The response side stalls at random at the current rate.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Watchdog: too long without any request or response moving ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic t_req make_access(input logic op, input logic [IDX_W-1:0] idx,
                                         input logic [LOW_W-1:0] wd,
                                         input logic [LOW_W-1:0] lo,
                                         input logic [HIGH_W-1:0] hi);
        t_req r;
        r.op           = op;
        r.reg_index    = idx;
        r.write_data   = wd;
        r.pins_in_low  = lo;
        r.pins_in_high = hi;
        return r;
    endfunction

    // Mapped registers are favored so the register state is exercised.
    function automatic logic [IDX_W-1:0] pick_index();
        logic [IDX_W-1:0] idx;
        case ($urandom_range(9))
            0, 1: idx = IDX_W'($urandom_range(IDX_FSEL_LAST));
            2:    idx = $urandom_range(1) ? IDX_SET0 : IDX_SET1;
            3:    idx = $urandom_range(1) ? IDX_CLR0 : IDX_CLR1;
            4:    idx = $urandom_range(1) ? IDX_LEV0 : IDX_LEV1;
            5:    idx = IDX_PUD;
            6:    idx = $urandom_range(1) ? IDX_PUDCLK0 : IDX_PUDCLK1;
            7:    idx = IDX_PULL0 + IDX_W'($urandom_range(IDX_PULL3 - IDX_PULL0));
            default: idx = IDX_W'($urandom_range(IDX_TOP));
        endcase
        return idx;
    endfunction

    // Data words: extremes, words rich in output selects, and plain random.
    function automatic logic [LOW_W-1:0] pick_word();
        logic [LOW_W-1:0] w;
        case ($urandom_range(7))
            0: w = '0;
            1: w = '1;
            2, 3: begin
                w = $urandom;
                for (int k = 0; k < PINS_PER_FSEL; k++) begin
                    if ($urandom_range(1)) w[k*FSEL_FIELD_W +: FSEL_FIELD_W] = FSEL_OUTPUT;
                end
            end
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Present one request, with random idle cycles first, and wait until it is taken.
    task automatic send_access(input t_req r);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.op           <= r.op;
        req_ch.reg_index    <= r.reg_index;
        req_ch.write_data   <= r.write_data;
        req_ch.pins_in_low  <= r.pins_in_low;
        req_ch.pins_in_high <= r.pins_in_high;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Short form for directed requests with random pin levels.
    task automatic issue(input logic op, input logic [IDX_W-1:0] idx,
                         input logic [LOW_W-1:0] wd);
        send_access(make_access(op, idx, wd, $urandom, HIGH_W'($urandom)));
    endtask

    // Stop sending and wait until every predicted response has come back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Select the pull scheme over the config port while the block is idle.
    task automatic set_scheme(input logic new_scheme);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SCHEME_ADDR;
        pwdata  <= CFG_DATA_W'(new_scheme);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_access(make_access(1'($urandom_range(1)), pick_index(), pick_word(),
                                    $urandom, HIGH_W'($urandom)));
        end
    endtask

    initial begin
        req_ch.valid        <= 1'b0;
        req_ch.op           <= 1'b0;
        req_ch.reg_index    <= '0;
        req_ch.write_data   <= '0;
        req_ch.pins_in_low  <= '0;
        req_ch.pins_in_high <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        i_rst_n <= 1'b0;
        src_idle_pct = 31;
        snk_idle_pct = 74;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, legacy scheme: selects, latch, levels, pull code and clocks.
        issue(1'b0, '0, '0);
        issue(OP_WRITE, '0, ALL_OUTPUT);
        issue(OP_WRITE, IDX_FSEL_LAST, '1);
        issue(1'b0, IDX_FSEL_LAST, '0);
        issue(OP_WRITE, IDX_SET0, '1);
        issue(OP_WRITE, IDX_SET1, '1);
        issue(OP_WRITE, IDX_CLR0, 32'h0000_ffff);
        issue(1'b0, IDX_SET0, '1);
        send_access(make_access(1'b0, IDX_LEV0, '0, '1, '0));
        send_access(make_access(1'b0, IDX_LEV1, '0, '0, '1));
        issue(OP_WRITE, IDX_FSEL_LAST, ALL_OUTPUT);
        send_access(make_access(1'b0, IDX_LEV1, '0, '0, '0));
        issue(OP_WRITE, IDX_PUD, '1);
        issue(1'b0, IDX_PUD, '0);
        issue(OP_WRITE, IDX_PUDCLK0, '1);
        issue(OP_WRITE, IDX_PUDCLK1, '1);
        issue(1'b0, IDX_PULL3, '0);
        issue(OP_WRITE, IDX_PULL3, '0);
        issue(1'b0, IDX_PULL0, '0);
        issue(OP_WRITE, IDX_LEV0, '1);
        issue(1'b0, IDX_GAP, '0);
        issue(OP_WRITE, IDX_TOP, '1);

        // Directed part, new scheme: latched pulls kept, per-pin pull words.
        set_scheme(1'b1);
        issue(1'b0, IDX_PULL0, '0);
        issue(1'b0, IDX_PULL3, '0);
        issue(OP_WRITE, IDX_PULL3, '1);
        issue(1'b0, IDX_PULL3, '0);
        issue(OP_WRITE, IDX_PUD, '1);
        issue(1'b0, IDX_PUDCLK0, '0);
        issue(OP_WRITE, IDX_CLR1, '1);
        issue(OP_WRITE, '0, '0);

        // Random part in three pacing phases, switching scheme within each.
        run_random(110);
        set_scheme(1'b0);
        run_random(110);

        src_idle_pct = 74;
        snk_idle_pct = 31;
        set_scheme(1'b1);
        run_random(110);
        set_scheme(1'b0);
        run_random(110);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(105);
        set_scheme(1'b1);
        run_random(105);

        drain();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/gpr_pkg.sv
sv/gpr_if.sv
sv/gpr_regs.sv
sv/gpio_port_registers_core.sv
sv/gpr_core_checker.sv
sim/gpio_access_checker.sv
sim/tb.sv
